>>> sv/voc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// voc_pkg: shared types and constants of the voice occlusion filter
// Fixed-point widths, register indexes, config struct and microcode word.
// ----------------------------------------------------------------------------
package voc_pkg;

    // sample and state widths
    localparam int SAMPLE_BITS         = 16;
    localparam int EXTRA_FRACTION_BITS = 8;
    localparam int FILT_W              = SAMPLE_BITS + EXTRA_FRACTION_BITS + 1;
    localparam int OCC_W               = 17;
    localparam int GAIN_W              = 16;

    // shared multiplier: signed A operand, unsigned B operand
    localparam int A_W    = FILT_W + 1;
    localparam int B_W    = OCC_W;
    localparam int PROD_W = A_W + B_W;
    localparam int RES_W  = PROD_W - 16;

    // Q1.16 constants; RAMP_K is scaled by 2^RAMP_SHIFT instead
    localparam logic [OCC_W-1:0] OCC_ONE = OCC_W'(65536);
    localparam logic [B_W-1:0]   RAMP_K  = B_W'(2097);
    localparam logic [B_W-1:0]   ALPHA_K = B_W'(60293);
    localparam logic [B_W-1:0]   DUCK_K  = B_W'(39322);

    localparam int RAMP_SHIFT = 20;
    localparam int Q16_SHIFT  = 16;
    localparam int GAIN_SHIFT = 14 + EXTRA_FRACTION_BITS;

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;

    // configuration port
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = OCC_W;
    typedef logic [CFG_INDEX_W-1:0] cfg_index_t;
    typedef logic [CFG_DATA_W-1:0]  cfg_data_t;

    localparam cfg_index_t REG_TARGET        = 3'd0;
    localparam cfg_index_t REG_LEFT_GAIN     = 3'd1;
    localparam cfg_index_t REG_RIGHT_GAIN    = 3'd2;
    localparam cfg_index_t REG_SOURCE_STEREO = 3'd3;
    localparam cfg_index_t REG_OUTPUT_STEREO = 3'd4;

    typedef struct packed {
        logic [OCC_W-1:0]  target_occlusion;
        logic [GAIN_W-1:0] l_gain;
        logic [GAIN_W-1:0] r_gain;
        logic              source_stereo;
        logic              output_stereo;
    } cfg_t;

    // microcode fields
    typedef enum logic [2:0] {
        A_RAMP, A_OCC, A_DIFF_L, A_DIFF_R, A_FILT_L, A_FILT_R, A_TMP_L, A_TMP_R
    } a_sel_t;

    typedef enum logic [2:0] {
        B_RAMP_K, B_ALPHA_K, B_DUCK_K, B_ALPHA, B_DUCK, B_LGAIN, B_RGAIN
    } b_sel_t;

    typedef enum logic [1:0] {
        SH_RAMP, SH_Q16, SH_GAIN
    } sh_sel_t;

    typedef enum logic [3:0] {
        WB_NONE, WB_OCC, WB_ALPHA, WB_DUCK, WB_FILT_L, WB_FILT_R,
        WB_TMP_L, WB_TMP_R, WB_OUT_L, WB_OUT_R
    } wb_sel_t;

    typedef enum logic [1:0] {
        COND_NEXT, COND_WAIT_IN, COND_WAIT_OUT
    } cond_t;

    localparam int STEP_W = 4;
    typedef logic [STEP_W-1:0] step_t;

    typedef struct packed {
        a_sel_t  a_sel;
        b_sel_t  b_sel;
        sh_sel_t sh_sel;
        wb_sel_t wb_sel;
        cond_t   cond;
        step_t   target;
    } ucode_t;

    // sequencer to datapath
    typedef struct packed {
        a_sel_t  a_sel;
        b_sel_t  b_sel;
        sh_sel_t sh_sel;
        wb_sel_t wb_sel;
        logic    load;
        logic    emit;
    } dp_ctrl_t;

endpackage

>>> sv/voc_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// voc_if: channel interfaces of the voice occlusion filter
// Sample frame in, result frame out, and the configuration write channel.
// ----------------------------------------------------------------------------
interface voc_frame_if;
    import voc_pkg::*;

    logic    valid;
    logic    ready;
    sample_t left_sample;
    sample_t right_sample;
    logic    start_req;

    modport source (output valid, left_sample, right_sample, start_req, input ready);
    modport sink   (input valid, left_sample, right_sample, start_req, output ready);
endinterface

interface voc_result_if;
    import voc_pkg::*;

    logic    valid;
    logic    ready;
    sample_t left_out;
    sample_t right_out;

    modport source (output valid, left_out, right_out, input ready);
    modport sink   (input valid, left_out, right_out, output ready);
endinterface

interface voc_cfg_if;
    import voc_pkg::*;

    logic       valid;
    logic       ready;
    cfg_index_t index;
    cfg_data_t  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

>>> sv/voc_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// voc_seq: microcode sequencer
// Step counter over a constant control store; waits for a frame and for
// a free output slot by conditional jumps.
// ----------------------------------------------------------------------------
module voc_seq (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              frame_valid,
    input  logic              out_free,
    output logic              frame_ready,
    output voc_pkg::dp_ctrl_t ctrl
);
    import voc_pkg::*;

    // One multiply issues per step; its writeback sits in the next word.
    function automatic ucode_t ucode_rom(step_t s);
        ucode_t w;
        w = '{a_sel: A_OCC, b_sel: B_RAMP_K, sh_sel: SH_Q16, wb_sel: WB_NONE,
              cond: COND_NEXT, target: '0};
        case (s)
            4'd0:  w.cond = COND_WAIT_IN;
            4'd1:  begin w.a_sel = A_RAMP; w.b_sel = B_RAMP_K; end
            4'd2:  begin w.wb_sel = WB_OCC; w.sh_sel = SH_RAMP; end
            4'd3:  begin w.a_sel = A_OCC; w.b_sel = B_ALPHA_K; end
            4'd4:  begin w.a_sel = A_OCC; w.b_sel = B_DUCK_K; w.wb_sel = WB_ALPHA; end
            4'd5:  begin w.a_sel = A_DIFF_L; w.b_sel = B_ALPHA; w.wb_sel = WB_DUCK; end
            4'd6:  begin w.a_sel = A_DIFF_R; w.b_sel = B_ALPHA; w.wb_sel = WB_FILT_L; end
            4'd7:  begin w.a_sel = A_FILT_L; w.b_sel = B_DUCK; w.wb_sel = WB_FILT_R; end
            4'd8:  begin w.a_sel = A_FILT_R; w.b_sel = B_DUCK; w.wb_sel = WB_TMP_L; end
            4'd9:  begin w.a_sel = A_TMP_L; w.b_sel = B_LGAIN; w.wb_sel = WB_TMP_R; end
            4'd10: begin
                w.a_sel  = A_TMP_R;
                w.b_sel  = B_RGAIN;
                w.wb_sel = WB_OUT_L;
                w.sh_sel = SH_GAIN;
            end
            4'd11: begin w.wb_sel = WB_OUT_R; w.sh_sel = SH_GAIN; end
            4'd12: w.cond = COND_WAIT_OUT;
            default: w.cond = COND_WAIT_OUT;
        endcase
        return w;
    endfunction

    step_t  step_reg;
    step_t  step_next;
    ucode_t word;
    logic   accept;
    logic   emit;

    assign word        = ucode_rom(step_reg);
    assign frame_ready = (word.cond == COND_WAIT_IN);
    assign accept      = frame_ready && frame_valid;
    assign emit        = (word.cond == COND_WAIT_OUT) && out_free;

    always_comb
    begin
        unique case (word.cond)
            COND_WAIT_IN:  step_next = accept ? step_t'(step_reg + 1'b1) : word.target;
            COND_WAIT_OUT: step_next = out_free ? word.target : step_reg;
            default:       step_next = step_t'(step_reg + 1'b1);
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

    assign ctrl = '{a_sel: word.a_sel, b_sel: word.b_sel, sh_sel: word.sh_sel,
                    wb_sel: word.wb_sel, load: accept, emit: emit};

endmodule

>>> sv/voc_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// voc_dp: datapath with one shared round-to-nearest multiplier
// Operand select and multiply into a product register, then rounding,
// sign restore and writeback into the state and scratch registers.
// ----------------------------------------------------------------------------
module voc_dp (
    input  logic              clk,
    input  logic              rst_n,
    input  voc_pkg::dp_ctrl_t ctrl,
    input  voc_pkg::cfg_t     cfg,
    input  voc_pkg::sample_t  left_sample,
    input  voc_pkg::sample_t  right_sample,
    input  logic              start_req,
    output voc_pkg::sample_t  res_l,
    output voc_pkg::sample_t  res_r
);
    import voc_pkg::*;

    localparam logic signed [RES_W:0] SAT_HI = (RES_W+1)'((1 << (SAMPLE_BITS - 1)) - 1);
    localparam logic signed [RES_W:0] SAT_LO = ~SAT_HI;

    function automatic sample_t sat_sample(logic signed [RES_W:0] v);
        sample_t s;
        if (v > SAT_HI)
            s = SAT_HI[SAMPLE_BITS-1:0];
        else if (v < SAT_LO)
            s = SAT_LO[SAMPLE_BITS-1:0];
        else
            s = v[SAMPLE_BITS-1:0];
        return s;
    endfunction

    // state
    logic [OCC_W-1:0]         occ_reg;
    logic signed [FILT_W-1:0] filt_l_reg;
    logic signed [FILT_W-1:0] filt_r_reg;
    // per-frame scratch
    sample_t                  xl_reg;
    sample_t                  xr_reg;
    logic [OCC_W-1:0]         alpha_reg;
    logic [OCC_W-1:0]         duck_reg;
    logic signed [FILT_W-1:0] tmp_l_reg;
    logic signed [FILT_W-1:0] tmp_r_reg;
    logic [PROD_W-1:0]        prod_reg;
    logic                     neg_reg;

    logic [OCC_W-1:0]         t_clamp;
    logic signed [FILT_W-1:0] x_l;
    logic signed [FILT_W-1:0] x_r;
    logic signed [A_W-1:0]    a_op;
    logic [B_W-1:0]           b_op;
    logic [A_W-1:0]           a_mag;
    logic [PROD_W:0]          half;
    logic [PROD_W:0]          rsum;
    logic [PROD_W:0]          rshift;
    logic [RES_W-1:0]         r_mag;
    logic signed [RES_W:0]    res;
    logic signed [RES_W:0]    occ_sum;
    logic signed [FILT_W-1:0] res_f;
    logic signed [FILT_W-1:0] sat_ext;

    assign t_clamp = (cfg.target_occlusion > OCC_ONE) ? OCC_ONE : cfg.target_occlusion;
    assign x_l     = {xl_reg[SAMPLE_BITS-1], xl_reg, {EXTRA_FRACTION_BITS{1'b0}}};
    assign x_r     = {xr_reg[SAMPLE_BITS-1], xr_reg, {EXTRA_FRACTION_BITS{1'b0}}};

    // operand select
    always_comb
    begin
        unique case (ctrl.a_sel)
            A_RAMP:   a_op = $signed({{(A_W-OCC_W){1'b0}}, t_clamp})
                           - $signed({{(A_W-OCC_W){1'b0}}, occ_reg});
            A_OCC:    a_op = $signed({{(A_W-OCC_W){1'b0}}, occ_reg});
            A_DIFF_L: a_op = {x_l[FILT_W-1], x_l} - {filt_l_reg[FILT_W-1], filt_l_reg};
            A_DIFF_R: a_op = {x_r[FILT_W-1], x_r} - {filt_r_reg[FILT_W-1], filt_r_reg};
            A_FILT_L: a_op = {filt_l_reg[FILT_W-1], filt_l_reg};
            A_FILT_R: a_op = {filt_r_reg[FILT_W-1], filt_r_reg};
            A_TMP_L:  a_op = {tmp_l_reg[FILT_W-1], tmp_l_reg};
            A_TMP_R:  a_op = {tmp_r_reg[FILT_W-1], tmp_r_reg};
            default:  a_op = '0;
        endcase

        unique case (ctrl.b_sel)
            B_RAMP_K:  b_op = RAMP_K;
            B_ALPHA_K: b_op = ALPHA_K;
            B_DUCK_K:  b_op = DUCK_K;
            B_ALPHA:   b_op = alpha_reg;
            B_DUCK:    b_op = duck_reg;
            B_LGAIN:   b_op = {{(B_W-GAIN_W){1'b0}}, cfg.l_gain};
            B_RGAIN:   b_op = {{(B_W-GAIN_W){1'b0}}, cfg.r_gain};
            default:   b_op = '0;
        endcase
    end

    // sign-magnitude multiply
    assign a_mag = a_op[A_W-1] ? A_W'(~a_op + 1'b1) : A_W'(a_op);

    always_ff @(posedge clk)
    begin
        prod_reg <= {{B_W{1'b0}}, a_mag} * {{A_W{1'b0}}, b_op};
        neg_reg  <= a_op[A_W-1];
    end

    // round half away from zero on the magnitude, then restore the sign
    always_comb
    begin
        unique case (ctrl.sh_sel)
            SH_RAMP: half = (PROD_W+1)'(1) << (RAMP_SHIFT - 1);
            SH_GAIN: half = (PROD_W+1)'(1) << (GAIN_SHIFT - 1);
            default: half = (PROD_W+1)'(1) << (Q16_SHIFT - 1);
        endcase
        rsum = {1'b0, prod_reg} + half;
        unique case (ctrl.sh_sel)
            SH_RAMP: rshift = rsum >> RAMP_SHIFT;
            SH_GAIN: rshift = rsum >> GAIN_SHIFT;
            default: rshift = rsum >> Q16_SHIFT;
        endcase
        r_mag = rshift[RES_W-1:0];
        res   = neg_reg ? -$signed({1'b0, r_mag}) : $signed({1'b0, r_mag});
    end

    assign occ_sum = $signed({{(RES_W+1-OCC_W){1'b0}}, occ_reg}) + res;
    assign res_f   = res[FILT_W-1:0];
    assign sat_ext = FILT_W'(sat_sample(res));

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg    <= '0;
            filt_l_reg <= '0;
            filt_r_reg <= '0;
        end
        else
        begin
            if (ctrl.load && start_req)
            begin
                occ_reg    <= t_clamp;
                filt_l_reg <= '0;
                filt_r_reg <= '0;
            end
            case (ctrl.wb_sel)
                WB_OCC:    occ_reg    <= occ_sum[OCC_W-1:0];
                WB_FILT_L: filt_l_reg <= filt_l_reg + res_f;
                WB_FILT_R: filt_r_reg <= filt_r_reg + res_f;
                default:   ;
            endcase
        end
    end

    // scratch registers
    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            xl_reg <= left_sample;
            xr_reg <= cfg.source_stereo ? right_sample : left_sample;
        end
        case (ctrl.wb_sel)
            WB_ALPHA: alpha_reg <= OCC_ONE - res[OCC_W-1:0];
            WB_DUCK:  duck_reg  <= OCC_ONE - res[OCC_W-1:0];
            WB_TMP_L: tmp_l_reg <= res_f;
            WB_TMP_R: tmp_r_reg <= res_f;
            WB_OUT_L: tmp_l_reg <= sat_ext;
            WB_OUT_R: tmp_r_reg <= cfg.output_stereo ? sat_ext : '0;
            default:  ;
        endcase
    end

    assign res_l = tmp_l_reg[SAMPLE_BITS-1:0];
    assign res_r = tmp_r_reg[SAMPLE_BITS-1:0];

endmodule

>>> sv/voice_occlusion_filter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// voice_occlusion_filter: occlusion stage of one voice
// Ramped occlusion level, one-pole lowpass, ducking and gain per channel.
// ----------------------------------------------------------------------------
// One stereo frame per transfer on frame gives one result transfer on result.
// A frame is taken in the first step of a microcoded sequencer that steps
// through 13 control words and feeds one shared 26x17 multiplier (multiply,
// then round and write back the next cycle), nine multiplies in a dependent
// chain per frame; its last step loads the result into the output register,
// and only then is a new frame taken. The next frame is taken as soon as the
// sequencer is back at its first step, even while the previous result still
// waits in the output register; the program holds on its last step only if
// that register is still full. Configuration writes are always taken
// (cfg.ready is high) and must only be made while no frame is in flight.
// Unknown register indexes are ignored.
// ----------------------------------------------------------------------------
module voice_occlusion_filter (
    input logic        clk,
    input logic        rst_n,
    voc_frame_if.sink  frame,
    voc_result_if.source result,
    voc_cfg_if.sink    cfg
);
    import voc_pkg::*;

    cfg_t     cfg_reg;
    dp_ctrl_t ctrl;
    logic     out_free;
    logic     out_valid_reg;
    sample_t  out_l_reg;
    sample_t  out_r_reg;
    sample_t  res_l;
    sample_t  res_r;

    // ---- configuration registers ----
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.target_occlusion <= '0;
            cfg_reg.l_gain           <= GAIN_W'(16384);
            cfg_reg.r_gain           <= GAIN_W'(16384);
            cfg_reg.source_stereo    <= 1'b1;
            cfg_reg.output_stereo    <= 1'b1;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_TARGET:        cfg_reg.target_occlusion <= cfg.data[OCC_W-1:0];
                REG_LEFT_GAIN:     cfg_reg.l_gain           <= cfg.data[GAIN_W-1:0];
                REG_RIGHT_GAIN:    cfg_reg.r_gain           <= cfg.data[GAIN_W-1:0];
                REG_SOURCE_STEREO: cfg_reg.source_stereo    <= cfg.data[0];
                REG_OUTPUT_STEREO: cfg_reg.output_stereo    <= cfg.data[0];
                default:           ;
            endcase
        end
    end

    // ---- control ----
    // out_free: the output register is empty or drains this cycle
    assign out_free = !out_valid_reg || result.ready;

    voc_seq u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .frame_valid (frame.valid),
        .out_free    (out_free),
        .frame_ready (frame.ready),
        .ctrl        (ctrl)
    );

    // ---- datapath ----
    voc_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctrl         (ctrl),
        .cfg          (cfg_reg),
        .left_sample  (frame.left_sample),
        .right_sample (frame.right_sample),
        .start_req    (frame.start_req),
        .res_l        (res_l),
        .res_r        (res_r)
    );

    // ---- output register ----
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ctrl.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.emit)
        begin
            out_l_reg <= res_l;
            out_r_reg <= res_r;
        end
    end

    assign result.valid     = out_valid_reg;
    assign result.left_out  = out_l_reg;
    assign result.right_out = out_r_reg;

endmodule

>>> bench/voice_occlusion_filter_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// voice_occlusion_filter_test: self-checking bench of the occlusion stage
// Streams stereo frames through the block under changing register settings
// and compares every result frame with a fixed-point model of the ramp,
// lowpass, ducking and gain stages, with random idling on both channels.
// ----------------------------------------------------------------------------
module voice_occlusion_filter_test;
    import voc_pkg::*;

    // 1218 frames with the longest source and sink gaps, plus register
    // writes, must finish within this limit.
    localparam int CYCLE_LIMIT  = 600000;
    // extra idle time at the end, after the last result is checked
    localparam int TAIL_CYCLES  = 40;
    localparam int RANDOM_ITEMS = 1200;

    typedef struct packed {
        sample_t left;
        sample_t right;
        logic    start;
    } frame_t;

    typedef struct packed {
        sample_t left;
        sample_t right;
    } out_pair_t;

    logic clk;
    logic rst_n;

    voc_frame_if  frame_ch ();
    voc_result_if result_ch ();
    voc_cfg_if    cfg_ch ();

    voice_occlusion_filter u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .frame  (frame_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    // ------------------------------------------------------------------
    // Clock, 20 ns period
    // ------------------------------------------------------------------
    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // ------------------------------------------------------------------
    // Model state: register copy and the three state words of the block
    // ------------------------------------------------------------------
    cfg_t                     cfg_shadow;
    logic [OCC_W-1:0]         occ_now;
    logic signed [FILT_W-1:0] lp_left;
    logic signed [FILT_W-1:0] lp_right;

    frame_t    pending_frames [$];  // frames waiting for the driver
    out_pair_t expected_out [$];    // predicted results, oldest first

    frame_t    on_wire;             // frame currently offered on frame_ch
    int        hold_off;            // source idle cycles still to insert
    int        stall_left;          // sink stall cycles still to insert
    bit        src_gaps;            // source idling enabled in this phase
    bit        sink_stalls;         // sink stalling enabled in this phase

    int        frames_queued;
    int        frames_taken;
    int        results_seen;
    int        mismatch_count;
    int        cfg_writes;
    int        settings_used;
    int        directed_frames;
    int        cycle_count;

    // a * b / 2^sh, rounded to nearest with halves away from zero; b >= 0
    function automatic longint scale_round(longint a, longint b, int sh);
        longint mag;
        longint r;
        mag = (a < 0) ? -a : a;
        r   = (mag * b + (longint'(1) <<< (sh - 1))) >>> sh;
        return (a < 0) ? -r : r;
    endfunction

    function automatic sample_t clamp_sample(longint v);
        longint hi;
        longint lo;
        hi = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
        lo = -hi - 1;
        if (v > hi)
            return sample_t'(hi);
        if (v < lo)
            return sample_t'(lo);
        return sample_t'(v);
    endfunction

    // Advance the model by one frame and queue the result it must produce.
    task automatic predict_frame(input frame_t f);
        longint    xl;
        longint    xr;
        longint    tgt;
        longint    occ;
        longint    alpha;
        longint    duck;
        longint    fl;
        longint    fr;
        out_pair_t o;
        xl  = longint'(f.left);
        // mono source: left sample feeds both filters
        xr  = cfg_shadow.source_stereo ? longint'(f.right) : xl;
        // targets above full occlusion act as full occlusion
        tgt = (cfg_shadow.target_occlusion > OCC_ONE) ? longint'(OCC_ONE)
                                                      : longint'(cfg_shadow.target_occlusion);
        occ = longint'(occ_now);
        fl  = longint'(lp_left);
        fr  = longint'(lp_right);
        // start request: settle at target, clear filters, then run normally
        if (f.start)
        begin
            occ = tgt;
            fl  = 0;
            fr  = 0;
        end
        // ramp; steps that round to zero leave the level where it is
        occ   = occ + scale_round(tgt - occ, longint'(RAMP_K), RAMP_SHIFT);
        alpha = longint'(OCC_ONE) - scale_round(occ, longint'(ALPHA_K), Q16_SHIFT);
        duck  = longint'(OCC_ONE) - scale_round(occ, longint'(DUCK_K), Q16_SHIFT);
        fl    = fl + scale_round(xl * (longint'(1) <<< EXTRA_FRACTION_BITS) - fl,
                                 alpha, Q16_SHIFT);
        fr    = fr + scale_round(xr * (longint'(1) <<< EXTRA_FRACTION_BITS) - fr,
                                 alpha, Q16_SHIFT);
        o.left  = clamp_sample(scale_round(scale_round(fl, duck, Q16_SHIFT),
                                           longint'(cfg_shadow.l_gain), GAIN_SHIFT));
        // mono output: right filter keeps running, right result is zero
        o.right = cfg_shadow.output_stereo
                ? clamp_sample(scale_round(scale_round(fr, duck, Q16_SHIFT),
                                           longint'(cfg_shadow.r_gain), GAIN_SHIFT))
                : sample_t'(0);
        occ_now  = occ[OCC_W-1:0];
        lp_left  = fl[FILT_W-1:0];
        lp_right = fr[FILT_W-1:0];
        expected_out = {expected_out, o};
    endtask

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch at result %0d: %s", $time, results_seen, msg);
        mismatch_count++;
    endtask

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic sample_t pick_sample();
        int r;
        r = $urandom_range(0, 9);
        case (r)
            0: return sample_t'(32767);
            1: return sample_t'(-32768);
            2: return sample_t'($urandom_range(0, 2) - 1);
            3, 4: return sample_t'($urandom_range(0, 511) - 256);
            default: return sample_t'($urandom);
        endcase
    endfunction

    function automatic logic [GAIN_W-1:0] pick_gain();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            2: return GAIN_W'(16384);
            default: return GAIN_W'($urandom);
        endcase
    endfunction

    function automatic logic [OCC_W-1:0] pick_target();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return OCC_ONE;
            2: return OCC_W'($urandom_range(65537, 131071));
            default: return OCC_W'($urandom_range(0, 65536));
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Frame driver: offers queued frames, predicts each one on its transfer
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            frame_ch.valid        <= 1'b0;
            frame_ch.left_sample  <= '0;
            frame_ch.right_sample <= '0;
            frame_ch.start_req    <= 1'b0;
        end
        else
        begin
            if (frame_ch.valid && frame_ch.ready)
            begin
                predict_frame(on_wire);
                frames_taken++;
            end
            if (!frame_ch.valid || frame_ch.ready)
            begin
                if (hold_off > 0)
                begin
                    hold_off--;
                    frame_ch.valid <= 1'b0;
                end
                else if (pending_frames.size() > 0)
                begin
                    on_wire = pending_frames.pop_front();
                    frame_ch.valid        <= 1'b1;
                    frame_ch.left_sample  <= on_wire.left;
                    frame_ch.right_sample <= on_wire.right;
                    frame_ch.start_req    <= on_wire.start;
                    hold_off = src_gaps ? pick_gap() : 0;
                end
                else
                begin
                    frame_ch.valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Result monitor: random backpressure, field-by-field compare
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            result_ch.ready <= 1'b0;
        end
        else
        begin
            if (result_ch.valid && result_ch.ready)
            begin
                if (expected_out.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected result L=%0d R=%0d",
                                              result_ch.left_out, result_ch.right_out));
                end
                else
                begin
                    out_pair_t want;
                    want = expected_out.pop_front();
                    if (result_ch.left_out !== want.left)
                        report_mismatch($sformatf("left_out %0d, expected %0d",
                                                  result_ch.left_out, want.left));
                    if (result_ch.right_out !== want.right)
                        report_mismatch($sformatf("right_out %0d, expected %0d",
                                                  result_ch.right_out, want.right));
                end
                results_seen++;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                result_ch.ready <= 1'b0;
            end
            else
            begin
                result_ch.ready <= 1'b1;
                if (sink_stalls && $urandom_range(0, 2) == 0)
                    stall_left = pick_gap();
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, expected_out.size());
            $display("** voice_occlusion_filter: FAILED **");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus sequencing helpers (called at a rising edge)
    // ------------------------------------------------------------------
    task automatic queue_frame(input sample_t l, input sample_t r, input logic s);
        frame_t f;
        f.left  = l;
        f.right = r;
        f.start = s;
        pending_frames = {pending_frames, f};
        frames_queued++;
    endtask

    // every queued frame transferred and every result checked
    task automatic wait_drained();
        while (frames_taken != frames_queued || expected_out.size() != 0)
            @(posedge clk);
    endtask

    // holds valid high; the caller lowers it after the last write of a group
    task automatic write_reg(input cfg_index_t idx, input cfg_data_t val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        case (idx)
            REG_TARGET:        cfg_shadow.target_occlusion = val[OCC_W-1:0];
            REG_LEFT_GAIN:     cfg_shadow.l_gain           = val[GAIN_W-1:0];
            REG_RIGHT_GAIN:    cfg_shadow.r_gain           = val[GAIN_W-1:0];
            REG_SOURCE_STEREO: cfg_shadow.source_stereo    = val[0];
            REG_OUTPUT_STEREO: cfg_shadow.output_stereo    = val[0];
            default: ;  // unmapped index, block ignores it
        endcase
        cfg_writes++;
    endtask

    task automatic end_settings();
        cfg_ch.valid <= 1'b0;
        settings_used++;
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        int left_to_send;
        int len;
        int i;
        logic s;

        // configuration channel idle from time zero
        rst_n                 = 1'b0;
        cfg_ch.valid          = 1'b0;
        cfg_ch.index          = REG_TARGET;
        cfg_ch.data           = '0;

        cfg_shadow.target_occlusion = '0;
        cfg_shadow.l_gain           = GAIN_W'(16384);
        cfg_shadow.r_gain           = GAIN_W'(16384);
        cfg_shadow.source_stereo    = 1'b1;
        cfg_shadow.output_stereo    = 1'b1;
        occ_now  = '0;
        lp_left  = '0;
        lp_right = '0;

        hold_off        = 0;
        stall_left      = 0;
        src_gaps        = 1'b0;
        sink_stalls     = 1'b0;
        frames_queued   = 0;
        frames_taken    = 0;
        results_seen    = 0;
        mismatch_count  = 0;
        cfg_writes      = 0;
        settings_used   = 1;
        cycle_count     = 0;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // --- directed: reset settings, sample extremes, start with zero target
        queue_frame(sample_t'(32767), sample_t'(-32768), 1'b0);
        queue_frame(sample_t'(-32768), sample_t'(32767), 1'b0);
        queue_frame(sample_t'(0), sample_t'(0), 1'b0);
        queue_frame(sample_t'(-1), sample_t'(1), 1'b0);
        queue_frame(sample_t'(32767), sample_t'(32767), 1'b1);
        wait_drained();

        // --- target above full scale, full gains, start settles at full
        write_reg(REG_TARGET, cfg_data_t'(131071));
        write_reg(REG_LEFT_GAIN, cfg_data_t'(65535));
        write_reg(REG_RIGHT_GAIN, cfg_data_t'(65535));
        write_reg(cfg_index_t'(REG_OUTPUT_STEREO + 1), '1);
        end_settings();
        sink_stalls = 1'b1;
        queue_frame(sample_t'(32767), sample_t'(-32768), 1'b1);
        queue_frame(sample_t'(-32768), sample_t'(32767), 1'b0);
        queue_frame(sample_t'(32767), sample_t'(32767), 1'b0);
        queue_frame(sample_t'(-32768), sample_t'(-32768), 1'b0);
        queue_frame(sample_t'(1), sample_t'(-1), 1'b0);
        wait_drained();

        // --- mono source into mono output, right gain zero
        write_reg(REG_SOURCE_STEREO, '0);
        write_reg(REG_OUTPUT_STEREO, '0);
        write_reg(REG_LEFT_GAIN, cfg_data_t'(20000));
        write_reg(REG_RIGHT_GAIN, '0);
        write_reg(cfg_index_t'((1 << CFG_INDEX_W) - 1), '0);
        end_settings();
        src_gaps = 1'b1;
        queue_frame(sample_t'(12345), sample_t'(-20000), 1'b0);
        queue_frame(sample_t'(-32768), sample_t'(32767), 1'b1);
        queue_frame(sample_t'(32767), sample_t'(-1), 1'b0);
        wait_drained();

        // --- back to stereo, zero target, level ramps down from full
        write_reg(REG_TARGET, '0);
        write_reg(REG_SOURCE_STEREO, cfg_data_t'(1));
        write_reg(REG_OUTPUT_STEREO, cfg_data_t'(1));
        write_reg(REG_LEFT_GAIN, '0);
        write_reg(REG_RIGHT_GAIN, cfg_data_t'(32768));
        end_settings();
        queue_frame(sample_t'(20000), sample_t'(-20000), 1'b0);
        queue_frame(sample_t'(-32768), sample_t'(32767), 1'b0);
        queue_frame(sample_t'(32767), sample_t'(-32768), 1'b0);
        queue_frame(sample_t'(100), sample_t'(-100), 1'b0);
        queue_frame(sample_t'(0), sample_t'(0), 1'b0);
        wait_drained();
        directed_frames = frames_queued;

        // --- random phases: fresh settings each time, then a run of frames
        left_to_send = RANDOM_ITEMS;
        while (left_to_send > 0)
        begin
            write_reg(REG_TARGET, cfg_data_t'(pick_target()));
            write_reg(REG_LEFT_GAIN, cfg_data_t'(pick_gain()));
            write_reg(REG_RIGHT_GAIN, cfg_data_t'(pick_gain()));
            write_reg(REG_SOURCE_STEREO, cfg_data_t'($urandom_range(0, 1)));
            write_reg(REG_OUTPUT_STEREO, cfg_data_t'($urandom_range(0, 1)));
            if ($urandom_range(0, 3) == 0)
                write_reg(cfg_index_t'($urandom_range(REG_OUTPUT_STEREO + 1,
                                                      (1 << CFG_INDEX_W) - 1)),
                          cfg_data_t'($urandom));
            end_settings();

            // idling mix per phase, including runs with none at all
            src_gaps    = ($urandom_range(0, 3) != 0);
            sink_stalls = ($urandom_range(0, 3) != 0);

            len = $urandom_range(40, 160);
            if (len > left_to_send)
                len = left_to_send;
            for (i = 0; i < len; i++)
            begin
                // often settle right away, else let the level ramp
                s = (i == 0) ? logic'($urandom_range(0, 1)) : ($urandom_range(0, 24) == 0);
                queue_frame(pick_sample(), pick_sample(), s);
            end
            left_to_send -= len;
            wait_drained();
        end

        repeat (TAIL_CYCLES) @(posedge clk);

        $display("ran %0d frames (%0d directed) under %0d settings, %0d register writes",
                 frames_taken, directed_frames, settings_used, cfg_writes);
        $display("checked %0d results in %0d cycles, %0d mismatches",
                 results_seen, cycle_count, mismatch_count);
        if (mismatch_count == 0 && expected_out.size() == 0)
            $display("** voice_occlusion_filter: PASSED **");
        else
            $display("** voice_occlusion_filter: FAILED **");
        $finish;
    end

endmodule
